[rtl/core/crc8w_pkg.sv]
// crc8w_pkg: shared types and constants for the CRC-8 checked word deframer.
// Used by the register block, the CRC unit, the deframer core and the top level.
// No dependencies.
package crc8w_pkg;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_CRC_INIT   = 2'd0;
    localparam logic [1:0] REG_CRC_POLY   = 2'd1;
    localparam logic [1:0] REG_WORD_COUNT = 2'd2;

    localparam logic [7:0] CRC_INIT_RST   = 8'hFF;
    localparam logic [7:0] CRC_POLY_RST   = 8'h31;
    localparam logic [3:0] WORD_COUNT_RST = 4'd1;

    // most words one reply may hold
    localparam logic [3:0] MAX_WORDS = 4'd8;

    // position of a byte within its three-byte group
    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    typedef struct packed {
        logic [7:0] crc_init;
        logic [7:0] crc_poly;
        logic [3:0] word_count;
    } cfg_t;

endpackage

[rtl/core/crc8_word_reply_checker_top.sv]
// crc8_word_reply_checker_top: CRC-8 checked word deframer, top level.
// Depends on crc8w_pkg, crc8w_regs and crc8w_deframe.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid / in_stall       reply_byte[7:0], start_of_reply
//  out      source     out_valid / out_stall     data_word[15:0], check_passed, last_word
//  cfg      APB slave  psel/penable/pwrite/pready paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One item per cycle sustained while the result is not stalled: the whole CRC byte
// update sits between the input register and the running CRC register.
// Reset (rst_n, async, low) clears the reply state and restores register defaults.
// A stalled result holds in the result register; the input register still takes
// one more item, then in_stall rises until the result moves on.
module crc8_word_reply_checker_top
    import crc8w_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         reply_byte,
    input  logic               start_of_reply,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        data_word,
    output logic               check_passed,
    output logic               last_word
);

    cfg_t cfg;

    crc8w_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crc8w_deframe u_deframe (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .reply_byte     (reply_byte),
        .start_of_reply (start_of_reply),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data_word      (data_word),
        .check_passed   (check_passed),
        .last_word      (last_word)
    );

endmodule

[rtl/core/crc8w_regs.sv]
// crc8w_regs: APB-style configuration registers (crc_init, crc_poly, word_count).
// Depends on crc8w_pkg.
module crc8w_regs
    import crc8w_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_CRC_INIT:   cfg_next.crc_init   = pwdata[7:0];
                REG_CRC_POLY:   cfg_next.crc_poly   = pwdata[7:0];
                REG_WORD_COUNT: cfg_next.word_count = pwdata[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CRC_INIT:   prdata = {24'd0, cfg_reg.crc_init};
            REG_CRC_POLY:   prdata = {24'd0, cfg_reg.crc_poly};
            REG_WORD_COUNT: prdata = {28'd0, cfg_reg.word_count};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_init   <= CRC_INIT_RST;
            cfg_reg.crc_poly   <= CRC_POLY_RST;
            cfg_reg.word_count <= WORD_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/crc8w_crc.sv]
// crc8w_crc: one-byte MSB-first CRC-8 update, unrolled over the eight bits.
// Depends on crc8w_pkg.
module crc8w_crc
    import crc8w_pkg::*;
(
    input  logic [7:0] crc_in,
    input  logic [7:0] data_in,
    input  logic [7:0] poly,
    output logic [7:0] crc_out
);

    always_comb
    begin
        logic [7:0] c;
        c = crc_in ^ data_in;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

[rtl/core/crc8w_deframe.sv]
// crc8w_deframe: input register, group tracking state, CRC check and result register.
// Depends on crc8w_pkg and crc8w_crc.
module crc8w_deframe
    import crc8w_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  reply_byte,
    input  logic        start_of_reply,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] data_word,
    output logic        check_passed,
    output logic        last_word
);

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  byte_reg;
    logic        start_reg;

    // reply state
    logic [7:0]  running_crc_reg, running_crc_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  low_reg, low_next;
    logic [3:0]  done_reg, done_next;
    logic        aborted_reg, aborted_next;

    // result stage
    logic        out_valid_reg, out_valid_next;
    logic [15:0] word_reg, word_next;
    logic        pass_reg, pass_next;
    logic        last_reg, last_next;

    logic        accept, out_free, advance;
    logic        aborted_eff;
    logic [1:0]  phase_eff;
    logic [3:0]  done_eff, done_inc, need;
    logic [7:0]  crc_seed, crc_upd;
    logic        pass, last;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign data_word    = word_reg;
    assign check_passed = pass_reg;
    assign last_word    = last_reg;

    // a start mark resets the group position, word count and abort flag before the byte is used
    assign aborted_eff = start_reg ? 1'b0 : aborted_reg;
    assign phase_eff   = start_reg ? PH_HIGH : phase_reg;
    assign done_eff    = start_reg ? 4'd0 : done_reg;
    assign done_inc    = done_eff + 4'd1;

    always_comb
    begin
        if (cfg.word_count == 4'd0)
            need = 4'd1;
        else if (cfg.word_count > MAX_WORDS)
            need = MAX_WORDS;
        else
            need = cfg.word_count;
    end

    assign crc_seed = (phase_eff == PH_LOW) ? running_crc_reg : cfg.crc_init;

    crc8w_crc u_crc (
        .crc_in  (crc_seed),
        .data_in (byte_reg),
        .poly    (cfg.crc_poly),
        .crc_out (crc_upd)
    );

    assign pass = (running_crc_reg == byte_reg);
    assign last = !pass || (done_inc >= need);

    always_comb
    begin
        in_valid_next    = in_valid_reg;
        running_crc_next = running_crc_reg;
        phase_next       = phase_reg;
        high_next        = high_reg;
        low_next         = low_reg;
        done_next        = done_reg;
        aborted_next     = aborted_reg;
        out_valid_next   = out_valid_reg && out_stall;
        word_next        = word_reg;
        pass_next        = pass_reg;
        last_next        = last_reg;

        if (advance)
        begin
            in_valid_next = 1'b0;
            aborted_next  = aborted_eff;
            phase_next    = phase_eff;
            done_next     = done_eff;
            if (!aborted_eff)
            begin
                case (phase_eff)
                    PH_LOW:
                    begin
                        low_next         = byte_reg;
                        running_crc_next = crc_upd;
                        phase_next       = PH_CRC;
                    end
                    PH_CRC:
                    begin
                        done_next        = done_inc;
                        phase_next       = PH_HIGH;
                        running_crc_next = cfg.crc_init;
                        aborted_next     = last;
                        out_valid_next   = 1'b1;
                        word_next        = pass ? {high_reg, low_reg} : 16'd0;
                        pass_next        = pass;
                        last_next        = last;
                    end
                    default:
                    begin
                        // high byte; a stray phase three lands here too
                        high_next        = byte_reg;
                        running_crc_next = crc_upd;
                        phase_next       = PH_LOW;
                    end
                endcase
            end
        end

        if (accept)
            in_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            running_crc_reg <= CRC_INIT_RST;
            phase_reg       <= PH_HIGH;
            high_reg        <= 8'd0;
            low_reg         <= 8'd0;
            done_reg        <= 4'd0;
            aborted_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            running_crc_reg <= running_crc_next;
            phase_reg       <= phase_next;
            high_reg        <= high_next;
            low_reg         <= low_next;
            done_reg        <= done_next;
            aborted_reg     <= aborted_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= reply_byte;
            start_reg <= start_of_reply;
        end
        word_reg <= word_next;
        pass_reg <= pass_next;
        last_reg <= last_next;
    end

endmodule
